// ----- hdl/policy_sorted_job_queue_defines.svh -----
// Assertion macros used by the checker file.
`ifndef POLICY_SORTED_JOB_QUEUE_DEFINES_SVH
`define POLICY_SORTED_JOB_QUEUE_DEFINES_SVH

// Condition that must hold on every clock edge out of reset.
`define PQS_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define PQS_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PQS_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/pqs_pkg.sv -----
`default_nettype none

package pqs_pkg;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_RESORT = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	localparam logic [1:0] POL_ARRIVAL = 2'd0;
	localparam logic [1:0] POL_RUNTIME = 2'd1;
	localparam logic [1:0] POL_PRIO    = 2'd2;

	localparam logic [19:0] WAIT_MAX = 20'hFFFFF;

	// per-cell operation
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD_NEW,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_SWAP_LO,
		CELL_SWAP_HI
	} cell_op_t;

	typedef enum logic {
		SQ_IDLE,
		SQ_SORT
	} sort_state_t;

	// first member in the highest bits, so tag lands at bit 0
	typedef struct packed {
		logic [31:0] arrival;
		logic [7:0]  prio;
		logic [15:0] run_time;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic [1:0]  pad;
		logic [4:0]  fill_count;
		logic [31:0] out_arrival;
		logic [7:0]  out_prio;
		logic [15:0] out_run_time;
		logic [15:0] out_tag;
		logic [19:0] wait_total;
		logic [4:0]  placement;
	} out_data_t;

	typedef struct packed {
		status_t   status;
		out_data_t data;
	} res_t;

	function automatic logic [31:0] key_of(entry_t e, logic [1:0] pol);
		logic [31:0] k;
		k = '0;
		case (pol)
			POL_ARRIVAL: k = e.arrival;
			POL_RUNTIME: k = {16'd0, e.run_time};
			POL_PRIO:    k = {24'd0, e.prio};
			default:     k = '0;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/pqs_cell.sv -----
`default_nettype none

// One queue slot: holds an entry and the run-time sum up to and including it.
module pqs_cell import pqs_pkg::*; #(
	parameter int PW = 20
) (
	input  wire logic          clk,
	input  wire cell_op_t      ctl,
	input  wire logic [1:0]    policy,
	input  wire entry_t        new_entry,
	input  wire logic [31:0]   new_key,
	input  wire entry_t        left_entry,
	input  wire logic [PW-1:0] left_prefix,
	input  wire entry_t        right_entry,
	input  wire logic [PW-1:0] right_prefix,
	input  wire logic [31:0]   right_key,
	input  wire logic [15:0]   head_rt,
	output entry_t             entry,
	output logic [PW-1:0]      prefix,
	output logic [31:0]        key,
	output logic               less_new,
	output logic               inv_right
);

	entry_t        entry_q;
	logic [PW-1:0] prefix_q;
	logic [PW-1:0] add_a;
	logic [PW-1:0] add_b;
	logic          add_sub;
	logic [PW-1:0] sum;

	assign entry     = entry_q;
	assign prefix    = prefix_q;
	assign key       = key_of(entry_q, policy);
	assign less_new  = new_key < key;
	assign inv_right = key > right_key;

	always_comb begin
		add_a   = left_prefix;
		add_b   = PW'(new_entry.run_time);
		add_sub = 1'b0;
		case (ctl)
			CELL_FROM_RIGHT: begin
				add_a   = right_prefix;
				add_b   = PW'(head_rt);
				add_sub = 1'b1;
			end
			CELL_SWAP_LO: begin
				add_b = PW'(right_entry.run_time);
			end
			default: begin
				add_a = left_prefix;
			end
		endcase
		sum = add_sub ? (add_a - add_b) : (add_a + add_b);
	end

	always_ff @(posedge clk) begin
		case (ctl)
			CELL_LOAD_NEW: begin
				entry_q  <= new_entry;
				prefix_q <= sum;
			end
			CELL_FROM_LEFT: begin
				entry_q  <= left_entry;
				prefix_q <= sum;
			end
			CELL_FROM_RIGHT: begin
				entry_q  <= right_entry;
				prefix_q <= sum;
			end
			CELL_SWAP_LO: begin
				entry_q  <= right_entry;
				prefix_q <= sum;
			end
			CELL_SWAP_HI: begin
				entry_q <= left_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/pqs_out_buf.sv -----
`default_nettype none

// Two-slot result buffer in front of the master port.
module pqs_out_buf import pqs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire res_t wr_data,
	output logic      space,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output res_t      rd_data
);

	res_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       rd;

	assign m_tvalid = cnt_q != 2'd0;
	assign rd       = m_tvalid && m_tready;
	assign space    = cnt_q < 2'd2;
	assign rd_data  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd);
		end
	end

endmodule

`default_nettype wire

// ----- hdl/policy_sorted_job_queue.sv -----
`default_nettype none

// Channel  Dir  tdata (low bit up)                                tuser
// s_       in   tag, run_time, prio, arrival                      opcode
// m_       out  placement, wait, tag, run_time, prio, arrival,    status
//               fill_count, 2 zero bits
// cfg_     in   sched_policy on cfg_wdata, written when cfg_wen
//
// Push, pop and no-op: the result is written to the result buffer as the item is accepted.
// Resort of two or more held jobs: one odd-even neighbour swap phase a cycle
// along the cell row; s_tready is low through the phases.
// A two-slot result buffer lets items in while a result waits; s_tready drops
// when both slots are taken or a resort is running.
// Reset empties the queue and selects arrival order; slot contents need no clearing.
module policy_sorted_job_queue import pqs_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // job_tag, run_time, prio_value, arrival_stamp
	input  wire logic [1:0]  s_tuser,  // opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [103:0]     m_tdata,  // placement, wait_total, out_tag, out_run_time,
	                                   // out_prio, out_arrival, fill_count, pad
	output logic [1:0]       m_tuser,  // status
	input  wire logic        cfg_wen,
	input  wire logic [1:0]  cfg_wdata
);

	localparam int N  = QUEUE_DEPTH;
	localparam int CW = $clog2(N + 1);
	localparam int PW = 16 + $clog2(N);

	function automatic logic [N-1:0] pfx_or(input logic [N-1:0] v);
		logic [N-1:0] r;
		r = v;
		for (int s = 1; s < N; s = s * 2) begin
			r = r | (r << s);
		end
		return r;
	endfunction

	logic [1:0]    policy_q;
	logic [CW-1:0] cnt_q;
	sort_state_t   state_q;
	sort_state_t   state_d;
	logic [CW-1:0] rounds_q;
	logic          phase_q;

	entry_t        din;
	logic [31:0]   new_key;
	opcode_t       op;
	logic          accept;
	logic          full;
	logic          buf_space;
	logic          sort_done;
	logic          res_wr;
	res_t          res;
	res_t          buf_out;

	entry_t        cell_e [N];
	logic [PW-1:0] cell_p [N];
	logic [31:0]   cell_k [N];
	entry_t        left_e [N];
	logic [PW-1:0] left_p [N];
	entry_t        right_e [N];
	logic [PW-1:0] right_p [N];
	logic [31:0]   right_k [N];
	cell_op_t      ctl [N];
	logic [N-1:0]  less_new;
	logic [N-1:0]  inv_right;

	logic [N-1:0]  occ;
	logic [N-1:0]  is_cnt;
	logic [N-1:0]  gt;
	logic [N-1:0]  found;
	logic [N-1:0]  take_new;
	logic [N-1:0]  shift_v;
	logic [N-1:0]  swp;
	logic [N-1:0]  swp_hi;
	logic [CW-1:0] pos;
	logic [PW-1:0] wsum;
	logic [PW-1:0] wsat;

	assign din       = entry_t'(s_tdata);
	assign op        = opcode_t'(s_tuser);
	assign new_key   = key_of(din, policy_q);
	assign s_tready  = (state_q == SQ_IDLE) && buf_space;
	assign accept    = s_tvalid && s_tready;
	assign full      = cnt_q == CW'(N);
	assign sort_done = (state_q == SQ_SORT) && (rounds_q == CW'(1));

	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == 0) begin : g_left0
			assign left_e[i] = din;
			assign left_p[i] = '0;
		end else begin : g_left
			assign left_e[i] = cell_e[i-1];
			assign left_p[i] = cell_p[i-1];
		end
		if (i == N - 1) begin : g_right_end
			assign right_e[i] = cell_e[i];
			assign right_p[i] = cell_p[i];
			assign right_k[i] = cell_k[i];
		end else begin : g_right
			assign right_e[i] = cell_e[i+1];
			assign right_p[i] = cell_p[i+1];
			assign right_k[i] = cell_k[i+1];
		end

		pqs_cell #(
			.PW(PW)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl[i]),
			.policy      (policy_q),
			.new_entry   (din),
			.new_key     (new_key),
			.left_entry  (left_e[i]),
			.left_prefix (left_p[i]),
			.right_entry (right_e[i]),
			.right_prefix(right_p[i]),
			.right_key   (right_k[i]),
			.head_rt     (cell_e[0].run_time),
			.entry       (cell_e[i]),
			.prefix      (cell_p[i]),
			.key         (cell_k[i]),
			.less_new    (less_new[i]),
			.inv_right   (inv_right[i])
		);
	end

	// insertion point: first held entry with a larger key, else the tail
	always_comb begin
		for (int i = 0; i < N; i++) begin
			occ[i]    = CW'(i) < cnt_q;
			is_cnt[i] = CW'(i) == cnt_q;
		end
		gt       = less_new & occ;
		found    = pfx_or(gt);
		take_new = ~(found << 1) & (gt | is_cnt);
		shift_v  = (found << 1) & {occ[N-2:0], 1'b1};
		for (int j = 0; j < N; j++) begin
			swp[j] = 1'b0;
			if (j < N - 1) begin
				swp[j] = (1'(j % 2) == phase_q) && occ[(j + 1) % N] && inv_right[j];
			end
		end
		swp_hi = swp << 1;
		pos    = '0;
		wsum   = '0;
		for (int i = 0; i < N; i++) begin
			if (take_new[i]) begin
				pos  = pos | CW'(i);
				wsum = wsum | left_p[i];
			end
		end
		wsat = (wsum > PW'(WAIT_MAX)) ? PW'(WAIT_MAX) : wsum;
	end

	// sort sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (accept && (op == OP_RESORT) && (cnt_q > CW'(1))) begin
					state_d = SQ_SORT;
				end
			end
			SQ_SORT: begin
				if (sort_done) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// sort sequencer: cell operations for push, pop and resort
	always_comb begin
		for (int i = 0; i < N; i++) begin
			ctl[i] = CELL_HOLD;
		end
		case (state_q)
			SQ_IDLE: begin
				if (accept && (op == OP_PUSH) && !full) begin
					for (int i = 0; i < N; i++) begin
						if (take_new[i]) begin
							ctl[i] = CELL_LOAD_NEW;
						end else if (shift_v[i]) begin
							ctl[i] = CELL_FROM_LEFT;
						end
					end
				end else if (accept && (op == OP_POP) && (cnt_q != '0)) begin
					for (int i = 0; i < N; i++) begin
						ctl[i] = CELL_FROM_RIGHT;
					end
				end
			end
			SQ_SORT: begin
				for (int i = 0; i < N; i++) begin
					if (swp[i]) begin
						ctl[i] = CELL_SWAP_LO;
					end else if (swp_hi[i]) begin
						ctl[i] = CELL_SWAP_HI;
					end
				end
			end
			default: begin
				for (int i = 0; i < N; i++) begin
					ctl[i] = CELL_HOLD;
				end
			end
		endcase
	end

	always_comb begin
		res                 = '0;
		res.status          = STAT_DONE;
		res.data.fill_count = 5'(cnt_q);
		if (!sort_done) begin
			case (op)
				OP_PUSH: begin
					if (full) begin
						res.status = STAT_FULL;
					end else begin
						res.data.placement  = 5'(pos);
						res.data.wait_total = 20'(wsat);
						res.data.fill_count = 5'(cnt_q + CW'(1));
					end
				end
				OP_POP: begin
					if (cnt_q == '0) begin
						res.status = STAT_EMPTY;
					end else begin
						res.data.out_tag      = cell_e[0].tag;
						res.data.out_run_time = cell_e[0].run_time;
						res.data.out_prio     = cell_e[0].prio;
						res.data.out_arrival  = cell_e[0].arrival;
						res.data.fill_count   = 5'(cnt_q - CW'(1));
					end
				end
				default: begin
					res.status = STAT_DONE;
				end
			endcase
		end
		res_wr = (accept && !((op == OP_RESORT) && (cnt_q > CW'(1)))) || sort_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_ARRIVAL;
			cnt_q    <= '0;
			state_q  <= SQ_IDLE;
			rounds_q <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				policy_q <= cfg_wdata;
			end
			if (accept && (op == OP_PUSH) && !full) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (accept && (op == OP_POP) && (cnt_q != '0)) begin
				cnt_q <= cnt_q - CW'(1);
			end
			state_q <= state_d;
			if (state_q == SQ_IDLE) begin
				rounds_q <= cnt_q;
				phase_q  <= 1'b0;
			end else begin
				rounds_q <= rounds_q - CW'(1);
				phase_q  <= ~phase_q;
			end
		end
	end

	pqs_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res),
		.space   (buf_space),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.rd_data (buf_out)
	);

	assign m_tdata = buf_out.data;
	assign m_tuser = buf_out.status;

endmodule

`default_nettype wire

// ----- hdl/pqs_checker.sv -----
`default_nettype none

`include "policy_sorted_job_queue_defines.svh"

module pqs_checker import pqs_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [103:0] m_tdata,
	input wire logic [1:0]   m_tuser
);

	out_data_t od;

	assign od = out_data_t'(m_tdata);

	`PQS_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`PQS_IMPLY(a_full_count, m_tvalid && (m_tuser == STAT_FULL), od.fill_count == 5'(QUEUE_DEPTH), "full refusal with queue not full")
	`PQS_IMPLY(a_empty_zero, m_tvalid && (m_tuser == STAT_EMPTY), (od.fill_count == 5'd0) && (od.out_tag == 16'd0) && (od.out_run_time == 16'd0), "empty pop with live data")
	`PQS_IMPLY(a_fail_no_place, m_tvalid && (m_tuser != STAT_DONE), (od.placement == 5'd0) && (od.wait_total == 20'd0), "placement on a refused item")
	`PQS_IMPLY(a_place_range, m_tvalid && (QUEUE_DEPTH < 32) && (od.placement != 5'd0), od.placement < od.fill_count, "placement beyond fill")

endmodule

bind policy_sorted_job_queue pqs_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_pqs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire

// ----- bench/tb_policy_sorted_job_queue.sv -----
`default_nettype none

module tb_policy_sorted_job_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import pqs_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam logic [1:0] OP_NOP = 2'd3;
	localparam logic [1:0] POL_UNKNOWN = 2'd3;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 2 * QUEUE_DEPTH + 4;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_wen = 1'b0;
	logic [1:0]   cfg_wdata = '0;

	// no random idling on either side while set
	bit calm = 1'b0;
	int unsigned hold_requests = 0;

	class job_queue_scoreboard;
		logic [1:0]  policy;
		entry_t      held_jobs[$];
		res_t        expected_results[$];
		int unsigned mismatches;
		int unsigned results_seen;

		function new();
			policy = POL_ARRIVAL;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void set_policy(logic [1:0] value);
			policy = value;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		function logic [31:0] order_key(entry_t job);
			case (policy)
				POL_ARRIVAL: return job.arrival;
				POL_RUNTIME: return {16'd0, job.run_time};
				POL_PRIO:    return {24'd0, job.prio};
				default:     return '0;
			endcase
		endfunction

		function void note_job(logic [1:0] op, logic [71:0] payload);
			entry_t      job;
			entry_t      moved;
			res_t        want;
			int unsigned slot;
			int unsigned ahead;
			int          j;
			job = entry_t'(payload);
			want = '0;
			case (op)
				OP_PUSH: begin
					if (held_jobs.size() >= QUEUE_DEPTH) begin
						want.status = STAT_FULL;
					end else begin
						slot = held_jobs.size();
						ahead = 0;
						// goes behind every entry whose key is not greater
						for (int i = 0; i < held_jobs.size(); i++) begin
							if (order_key(job) < order_key(held_jobs[i])) begin
								slot = i;
								break;
							end
							ahead += held_jobs[i].run_time;
						end
						held_jobs.insert(slot, job);
						want.data.placement = slot[4:0];
						want.data.wait_total = (ahead > WAIT_MAX) ? WAIT_MAX : ahead[19:0];
					end
				end
				OP_POP: begin
					if (held_jobs.size() == 0) begin
						want.status = STAT_EMPTY;
					end else begin
						want.data.out_tag = held_jobs[0].tag;
						want.data.out_run_time = held_jobs[0].run_time;
						want.data.out_prio = held_jobs[0].prio;
						want.data.out_arrival = held_jobs[0].arrival;
						held_jobs.delete(0);
					end
				end
				OP_RESORT: begin
					// stable insertion sort
					for (int i = 1; i < held_jobs.size(); i++) begin
						moved = held_jobs[i];
						j = i;
						while (j > 0 && order_key(held_jobs[j - 1]) > order_key(moved)) begin
							held_jobs[j] = held_jobs[j - 1];
							j--;
						end
						held_jobs[j] = moved;
					end
				end
				default: begin
				end
			endcase
			want.data.fill_count = 5'(held_jobs.size());
			expected_results.push_back(want);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: %s expected %0h, got %0h",
						results_seen, field, want, got);
			end
		endfunction

		function void check_result(logic [1:0] status, logic [103:0] payload);
			out_data_t got;
			res_t      want;
			got = out_data_t'(payload);
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing pending", results_seen);
				return;
			end
			want = expected_results.pop_front();
			compare_field("status", 32'(want.status), 32'(status));
			compare_field("placement", 32'(want.data.placement), 32'(got.placement));
			compare_field("wait_total", 32'(want.data.wait_total), 32'(got.wait_total));
			compare_field("out_tag", 32'(want.data.out_tag), 32'(got.out_tag));
			compare_field("out_run_time", 32'(want.data.out_run_time),
				32'(got.out_run_time));
			compare_field("out_prio", 32'(want.data.out_prio), 32'(got.out_prio));
			compare_field("out_arrival", want.data.out_arrival, got.out_arrival);
			compare_field("fill_count", 32'(want.data.fill_count), 32'(got.fill_count));
		endfunction
	endclass

	job_queue_scoreboard sb;

	policy_sorted_job_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mix of full range, tiny values (many equal keys) and all ones
	function automatic logic [31:0] pick_value(int unsigned bits);
		logic [31:0] mask;
		mask = (bits >= 32) ? 32'hFFFF_FFFF : (32'd1 << bits) - 32'd1;
		case ($urandom_range(3))
			0:       return $urandom & mask;
			1:       return $urandom_range(3);
			2:       return mask;
			default: return $urandom_range(15);
		endcase
	endfunction

	function automatic entry_t random_job();
		entry_t job;
		job.tag = 16'($urandom);
		job.run_time = 16'(pick_value(16));
		job.prio = 8'(pick_value(8));
		job.arrival = pick_value(32);
		return job;
	endfunction

	task automatic offer_job(logic [1:0] op, entry_t job);
		if (!calm) begin
			while ($urandom_range(99) < 18) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= job;
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	// only written once every result is back and any resort has settled
	task automatic write_policy(logic [1:0] value);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wen)
				sb.set_policy(cfg_wdata);
			if (s_tvalid && s_tready)
				sb.note_job(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
		end
	end

	initial begin : result_sink
		int unsigned hold_left;
		int unsigned holds_served;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 18);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_policy_sorted_job_queue failed");
		$finish;
	end

	initial begin : stimulus
		entry_t      job;
		logic [1:0]  op;
		int unsigned roll;
		int unsigned push_share;
		int unsigned item_no;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue corners, then fill past the top under arrival order
		offer_job(OP_POP, random_job());
		offer_job(OP_RESORT, random_job());
		offer_job(OP_NOP, random_job());
		for (int k = 0; k <= QUEUE_DEPTH; k++) begin
			job.tag = (k == 0) ? 16'hFFFF : 16'(k * 4099);
			job.run_time = (k % 2 == 1) ? 16'hFFFF : 16'(k);
			job.prio = (k < 8) ? 8'hFF : 8'(k % 4);
			job.arrival = (k % 4 == 0) ? 32'hFFFF_FFFF : 32'(k % 4);
			offer_job(OP_PUSH, job);
		end
		write_policy(POL_RUNTIME);
		offer_job(OP_RESORT, random_job());
		offer_job(OP_POP, random_job());
		write_policy(POL_PRIO);
		offer_job(OP_RESORT, random_job());
		offer_job(OP_POP, random_job());
		// unknown policy: push goes to the tail, resort leaves order alone
		write_policy(POL_UNKNOWN);
		offer_job(OP_PUSH, random_job());
		offer_job(OP_RESORT, random_job());
		offer_job(OP_POP, random_job());

		item_no = 0;
		for (int p = 0; p < 8; p++) begin
			write_policy(2'((p * 3) % 4));
			calm = (p == 2);
			if (p == 5)
				hold_requests++;
			for (int n = 0; n < 100; n++) begin
				// alternate filling and draining stretches so both ends get hit
				push_share = ((item_no / 40) % 2 == 0) ? 72 : 40;
				roll = $urandom_range(99);
				if (roll < 8)
					op = OP_RESORT;
				else if (roll < 12)
					op = OP_NOP;
				else if (roll < push_share)
					op = OP_PUSH;
				else
					op = OP_POP;
				offer_job(op, random_job());
				item_no++;
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_policy_sorted_job_queue passed");
		else
			$display("tb_policy_sorted_job_queue failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/pqs_pkg.sv
hdl/pqs_cell.sv
hdl/pqs_out_buf.sv
hdl/policy_sorted_job_queue.sv
hdl/pqs_checker.sv
bench/tb_policy_sorted_job_queue.sv
